>>> rtl/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg
// Shared types and constants of the primitive assembler: mode codes, queue
// entry layout and back-end sequencer states.
// ----------------------------------------------------------------------------
package pa_pkg;

    localparam int HANDLE_W     = 16;
    localparam int COUNT_W      = 3;
    localparam int MODE_W       = 3;
    localparam int POS_W        = 16;
    localparam int MAX_RESULTS  = 32;
    localparam int LAST_W       = $clog2(MAX_RESULTS);
    localparam int STORE_AW_MAX = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int PADDR_W      = 2;
    localparam int PDATA_W      = 32;

    localparam logic [PADDR_W-1:0] ADDR_MODE = 2'd0;

    typedef enum logic [MODE_W-1:0] {
        PM_POINTS  = 3'd0,
        PM_LINES   = 3'd1,
        PM_TRIS    = 3'd2,
        PM_STRIP   = 3'd3,
        PM_FAN     = 3'd4,
        PM_QUADS   = 3'd5,
        PM_POLYGON = 3'd6,
        PM_NONE    = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        K_NONE,
        K_PRIM,
        K_POLY
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic                    wr_en;
        logic [STORE_AW_MAX-1:0] wr_addr;
        logic [HANDLE_W-1:0]     handle;
        logic [HANDLE_W-1:0]     a;
        logic [HANDLE_W-1:0]     b;
        logic [HANDLE_W-1:0]     c;
        logic [HANDLE_W-1:0]     d;
        logic [COUNT_W-1:0]      count;
        logic [LAST_W-1:0]       poly_last;
        logic                    poly_ovf;
    } entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD,
        BK_OUT
    } back_state_t;

endpackage

>>> rtl/pa_if.sv
// ----------------------------------------------------------------------------
// pa_if
// Valid/ready channels of the primitive assembler: vertex beats in,
// primitive beats out.
// ----------------------------------------------------------------------------
interface pa_vtx_if
    import pa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] vertex_handle;
    logic                end_of_batch;

    modport source (output valid, output vertex_handle, output end_of_batch, input ready);
    modport sink   (input valid, input vertex_handle, input end_of_batch, output ready);
endinterface

interface pa_prim_if
    import pa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] handle_a;
    logic [HANDLE_W-1:0] handle_b;
    logic [HANDLE_W-1:0] handle_c;
    logic [HANDLE_W-1:0] handle_d;
    logic [COUNT_W-1:0]  vertex_count;
    logic                polygon_part;
    logic                end_of_primitive;
    logic                polygon_overflow;

    modport source (
        output valid, output handle_a, output handle_b, output handle_c,
        output handle_d, output vertex_count, output polygon_part,
        output end_of_primitive, output polygon_overflow, input ready
    );
    modport sink (
        input valid, input handle_a, input handle_b, input handle_c,
        input handle_d, input vertex_count, input polygon_part,
        input end_of_primitive, input polygon_overflow, output ready
    );
endinterface

>>> rtl/primitive_assembler.sv
// ----------------------------------------------------------------------------
// primitive_assembler
// Groups a stream of vertex handles into points, lines, triangles, strips,
// fans, quads or polygon runs according to the mode register.
//
//   port   dir   handshake        beat
//   vtx    in    valid/ready      vertex_handle, end_of_batch
//   prim   out   valid/ready      handle_a..d, vertex_count, flags
//   apb    in    psel/penable     mode register at byte address 0
//
// front takes one vertex per cycle while the four-entry queue has room
// back retires one queue entry per cycle when the output register drains,
// except during a polygon run, which reads each vertex through the
// registered read port of the polygon store; vertices queue up meanwhile
// rst_n clears position, flags, queue and output valid; no clearing pass
// ----------------------------------------------------------------------------
module primitive_assembler
    import pa_pkg::*;
#(
    parameter int POLYGON_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    pa_vtx_if.sink             vtx,
    pa_prim_if.source          prim
);

    mode_t  mode_reg;
    logic   push, pop, q_full, q_nonempty;
    entry_t push_entry, head;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODE) ? PDATA_W'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= PM_POINTS;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_MODE))
        begin
            mode_reg <= mode_t'(pwdata[MODE_W-1:0]);
        end
    end

    pa_front #(
        .POLYGON_DEPTH (POLYGON_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (mode_reg),
        .vtx    (vtx),
        .q_full (q_full),
        .push   (push),
        .entry  (push_entry)
    );

    pa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .nonempty   (q_nonempty),
        .head       (head)
    );

    pa_back #(
        .POLYGON_DEPTH (POLYGON_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .head       (head),
        .pop        (pop),
        .prim       (prim)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        prim.valid |-> (prim.vertex_count == 3'd1 || prim.vertex_count == 3'd2 ||
                        prim.vertex_count == 3'd3 || prim.vertex_count == 3'd4))
        else $error("vertex_count out of range");

    a_poly_single: assert property (@(posedge clk) disable iff (!rst_n)
        (prim.valid && prim.polygon_part) |->
            (prim.vertex_count == 3'd1 && prim.handle_b == '0 &&
             prim.handle_c == '0 && prim.handle_d == '0))
        else $error("polygon beat carries more than one vertex");

    a_prim_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (prim.valid && !prim.polygon_part) |->
            (prim.end_of_primitive && !prim.polygon_overflow))
        else $error("primitive beat without end flag or with overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_nonempty)
        else $error("queue popped while empty");

endmodule

>>> rtl/pa_front.sv
// ----------------------------------------------------------------------------
// pa_front
// Accepts vertex beats, tracks batch position and recent handles, and turns
// each vertex into one queue entry: a store write (within the store depth)
// plus a primitive, a polygon burst request, or nothing.
// ----------------------------------------------------------------------------
module pa_front
    import pa_pkg::*;
#(
    parameter int POLYGON_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mode_t         mode,
    pa_vtx_if.sink        vtx,
    input  logic          q_full,
    output logic          push,
    output entry_t        entry
);

    localparam int POLY_MAX = (POLYGON_DEPTH < MAX_RESULTS) ? POLYGON_DEPTH : MAX_RESULTS;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [1:0]          phase_reg, phase_next;
    logic                ovf_reg, ovf_next;
    logic [HANDLE_W-1:0] anchor_reg, anchor_next;
    logic [HANDLE_W-1:0] r0_reg, r1_reg, r2_reg;
    logic [HANDLE_W-1:0] v;
    logic                beyond;
    logic                accept;

    assign vtx.ready = !q_full;
    assign accept    = vtx.valid && !q_full;
    assign push      = accept;
    assign v         = vtx.vertex_handle;
    assign beyond    = (pos_reg >= POS_W'(POLYGON_DEPTH));

    always_comb
    begin
        entry         = '0;
        entry.kind    = K_NONE;
        entry.wr_en   = !beyond;
        entry.wr_addr = pos_reg[STORE_AW_MAX-1:0];
        entry.handle  = v;
        case (mode)
            PM_POINTS:
            begin
                entry.kind  = K_PRIM;
                entry.a     = v;
                entry.count = 3'd1;
            end
            PM_LINES:
            begin
                if (pos_reg[0])
                begin
                    entry.kind  = K_PRIM;
                    entry.a     = r2_reg;
                    entry.b     = v;
                    entry.count = 3'd2;
                end
            end
            PM_TRIS:
            begin
                if (phase_reg == 2'd2)
                begin
                    entry.kind  = K_PRIM;
                    entry.a     = r1_reg;
                    entry.b     = r2_reg;
                    entry.c     = v;
                    entry.count = 3'd3;
                end
            end
            PM_STRIP:
            begin
                if (pos_reg > POS_W'(1))
                begin
                    entry.kind  = K_PRIM;
                    entry.a     = pos_reg[0] ? r2_reg : r1_reg;
                    entry.b     = pos_reg[0] ? r1_reg : r2_reg;
                    entry.c     = v;
                    entry.count = 3'd3;
                end
            end
            PM_FAN:
            begin
                if (pos_reg > POS_W'(1))
                begin
                    entry.kind  = K_PRIM;
                    entry.a     = anchor_reg;
                    entry.b     = r2_reg;
                    entry.c     = v;
                    entry.count = 3'd3;
                end
            end
            PM_QUADS:
            begin
                if (pos_reg[1:0] == 2'd3)
                begin
                    entry.kind  = K_PRIM;
                    entry.a     = r0_reg;
                    entry.b     = r1_reg;
                    entry.c     = r2_reg;
                    entry.d     = v;
                    entry.count = 3'd4;
                end
            end
            PM_POLYGON:
            begin
                if (vtx.end_of_batch && pos_reg > POS_W'(1))
                begin
                    entry.kind      = K_POLY;
                    entry.poly_ovf  = ovf_reg || (pos_reg >= POS_W'(POLY_MAX));
                    entry.poly_last = (pos_reg >= POS_W'(POLY_MAX)) ?
                                      LAST_W'(POLY_MAX - 1) : pos_reg[LAST_W-1:0];
                end
            end
            default:
            begin
                entry.kind = K_NONE;
            end
        endcase
    end

    always_comb
    begin
        anchor_next = (pos_reg == '0) ? v : anchor_reg;
        if (vtx.end_of_batch)
        begin
            pos_next   = '0;
            phase_next = 2'd0;
            ovf_next   = 1'b0;
        end
        else
        begin
            pos_next   = (pos_reg == {POS_W{1'b1}}) ? (pos_reg - POS_W'(11)) : (pos_reg + 1'b1);
            phase_next = (phase_reg == 2'd2) ? 2'd0 : (phase_reg + 1'b1);
            ovf_next   = ovf_reg || beyond;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= 2'd0;
            ovf_reg    <= 1'b0;
            anchor_reg <= '0;
            r0_reg     <= '0;
            r1_reg     <= '0;
            r2_reg     <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            ovf_reg    <= ovf_next;
            anchor_reg <= anchor_next;
            r0_reg     <= r1_reg;
            r1_reg     <= r2_reg;
            r2_reg     <= v;
        end
    end

endmodule

>>> rtl/pa_queue.sv
// ----------------------------------------------------------------------------
// pa_queue
// Small FIFO of classified vertex entries between front and back.
// ----------------------------------------------------------------------------
module pa_queue
    import pa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   nonempty,
    output entry_t head
);

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    entry_t          slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QP_W:0]   count_reg;

    assign full     = (count_reg == (QP_W+1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/pa_back.sv
// ----------------------------------------------------------------------------
// pa_back
// Executes queue entries: writes the polygon store, emits primitives and
// runs polygon bursts out of the store into the output register.
// ----------------------------------------------------------------------------
module pa_back
    import pa_pkg::*;
#(
    parameter int POLYGON_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_nonempty,
    input  entry_t    head,
    output logic      pop,
    pa_prim_if.source prim
);

    localparam int AW = $clog2(POLYGON_DEPTH);

    logic [HANDLE_W-1:0] store_mem [POLYGON_DEPTH];
    logic [HANDLE_W-1:0] rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;

    back_state_t         state_reg, state_next;
    logic [LAST_W-1:0]   idx_reg, idx_next;
    logic [LAST_W-1:0]   last_reg, last_next;
    logic                povf_reg, povf_next;

    logic                ovld_reg, ovld_next;
    logic                load;
    logic [HANDLE_W-1:0] oa_next, ob_next, oc_next, od_next;
    logic [COUNT_W-1:0]  ocnt_next;
    logic                opart_next, oeop_next, oovf_next;
    logic [HANDLE_W-1:0] oa_reg, ob_reg, oc_reg, od_reg;
    logic [COUNT_W-1:0]  ocnt_reg;
    logic                opart_reg, oeop_reg, oovf_reg;
    logic                slot_free;

    assign slot_free = !ovld_reg || prim.ready;
    assign rd_addr   = AW'(idx_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        povf_next  = povf_reg;
        ovld_next  = ovld_reg && !prim.ready;
        load       = 1'b0;
        pop        = 1'b0;
        mem_we     = 1'b0;
        oa_next    = head.a;
        ob_next    = head.b;
        oc_next    = head.c;
        od_next    = head.d;
        ocnt_next  = head.count;
        opart_next = 1'b0;
        oeop_next  = 1'b1;
        oovf_next  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_nonempty && slot_free)
                begin
                    pop    = 1'b1;
                    mem_we = head.wr_en;
                    case (head.kind)
                        K_PRIM:
                        begin
                            load      = 1'b1;
                            ovld_next = 1'b1;
                        end
                        K_POLY:
                        begin
                            idx_next   = '0;
                            last_next  = head.poly_last;
                            povf_next  = head.poly_ovf;
                            state_next = BK_RD;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_RD:
            begin
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                oa_next    = rd_data_reg;
                ob_next    = '0;
                oc_next    = '0;
                od_next    = '0;
                ocnt_next  = 3'd1;
                opart_next = 1'b1;
                oeop_next  = (idx_reg == last_reg);
                oovf_next  = povf_reg;
                if (slot_free)
                begin
                    load      = 1'b1;
                    ovld_next = 1'b1;
                    if (idx_reg == last_reg)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = BK_RD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[AW'(head.wr_addr)] <= head.handle;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
            last_reg  <= '0;
            povf_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            povf_reg  <= povf_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            oa_reg    <= oa_next;
            ob_reg    <= ob_next;
            oc_reg    <= oc_next;
            od_reg    <= od_next;
            ocnt_reg  <= ocnt_next;
            opart_reg <= opart_next;
            oeop_reg  <= oeop_next;
            oovf_reg  <= oovf_next;
        end
    end

    assign prim.valid            = ovld_reg;
    assign prim.handle_a         = oa_reg;
    assign prim.handle_b         = ob_reg;
    assign prim.handle_c         = oc_reg;
    assign prim.handle_d         = od_reg;
    assign prim.vertex_count     = ocnt_reg;
    assign prim.polygon_part     = opart_reg;
    assign prim.end_of_primitive = oeop_reg;
    assign prim.polygon_overflow = oovf_reg;

endmodule
